[sv/nmda_pkg.sv]
// nmda_pkg: shared types, constants and functions of the nmda synapse block
// depends on nothing; used by nmda_ctrl, nmda_dpath and nmda_synapse_conductance
`default_nettype none

package nmda_pkg;

    // exponent table depth default
    localparam int NMDA_EXP_DEPTH = 256;

    // 0.062 * log2(e) in q.24 log2 units per mv, applied to q8.8 voltage
    localparam logic signed [23:0] NMDA_LOG2_SLOPE = 24'sd1500673;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_PEAK     = 3'd0,
        CFG_REVERSAL = 3'd1,
        CFG_RISE     = 3'd2,
        CFG_FALL     = 3'd3,
        CFG_NORM     = 3'd4,
        CFG_MG       = 3'd5,
        CFG_SHUTDOWN = 3'd6
    } cfg_idx_t;

    // register reset values
    localparam logic [31:0] RST_PEAK     = 32'd16777;
    localparam logic [15:0] RST_NORM     = 16'd4096;
    localparam logic [15:0] RST_MG       = 16'd1147;
    localparam logic [19:0] RST_SHUTDOWN = 20'd2500;

    // datapath operations
    typedef enum logic [3:0] {
        OP_SPK_RISE,
        OP_SPK_FALL,
        OP_DEC_RN,
        OP_DEC_RX,
        OP_DEC_FN,
        OP_DEC_FX,
        OP_Z,
        OP_T,
        OP_P,
        OP_W,
        OP_N,
        OP_B
    } op_t;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic wb;
        logic lut;
        logic div;
        logic emit;
        logic side;
        op_t  op;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic active;
        logic div_done;
        logic out_free;
    } sts_t;

    // 2^f for f in q0.16, result q1.16, cubic in horner form
    function automatic logic [16:0] pow2_frac(input logic [15:0] f);
        logic [63:0] acc;
        acc = 64'd5184;
        acc = 64'd14752 + ((acc * {48'd0, f}) >> 16);
        acc = 64'd45599 + ((acc * {48'd0, f}) >> 16);
        acc = 64'd65536 + ((acc * {48'd0, f}) >> 16);
        return acc[16:0];
    endfunction

endpackage

`default_nettype wire

[sv/nmda_ctrl.sv]
// nmda_ctrl: sequencing state machine of the nmda synapse block
// depends on nmda_pkg; drives nmda_dpath through cmd_t
`default_nettype none

module nmda_ctrl import nmda_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    input  wire logic s_opcode,
    output logic      s_tready,
    input  sts_t      sts,
    output cmd_t      cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_WB   = 6'b000100,
        S_LUT  = 6'b001000,
        S_DIV  = 6'b010000,
        S_EMIT = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic   side_reg, side_next;

    assign s_tready = (state_reg == S_IDLE);

    // next state and operation
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        side_next  = side_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    side_next = 1'b0;
                    if (!s_opcode) begin
                        op_next    = OP_SPK_RISE;
                        state_next = S_MUL;
                    end else if (sts.active) begin
                        op_next    = OP_DEC_RN;
                        state_next = S_MUL;
                    end else begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_MUL: state_next = S_WB;
            S_WB: begin
                state_next = S_MUL;
                unique case (op_reg)
                    OP_SPK_RISE: op_next = OP_SPK_FALL;
                    OP_SPK_FALL: state_next = S_IDLE;
                    OP_DEC_RN:   op_next = OP_DEC_RX;
                    OP_DEC_RX:   op_next = OP_DEC_FN;
                    OP_DEC_FN:   op_next = OP_DEC_FX;
                    OP_DEC_FX:   op_next = OP_Z;
                    OP_Z:        state_next = S_LUT;
                    OP_T:        state_next = S_DIV;
                    OP_P:        op_next = OP_W;
                    OP_W:        op_next = OP_N;
                    OP_N:        op_next = OP_B;
                    OP_B: begin
                        if (!side_reg) begin
                            side_next = 1'b1;
                            op_next   = OP_Z;
                        end else begin
                            state_next = S_EMIT;
                        end
                    end
                    default:     state_next = S_IDLE;
                endcase
            end
            S_LUT: begin
                op_next    = OP_T;
                state_next = S_MUL;
            end
            S_DIV: begin
                if (sts.div_done) begin
                    op_next    = OP_P;
                    state_next = S_MUL;
                end
            end
            S_EMIT: begin
                if (sts.out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            op_reg    <= OP_SPK_RISE;
            side_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            side_reg  <= side_next;
        end
    end

    // command decode
    always_comb begin
        cmd.accept = (state_reg == S_IDLE) && s_tvalid;
        cmd.wb     = (state_reg == S_WB);
        cmd.lut    = (state_reg == S_LUT);
        cmd.div    = (state_reg == S_DIV);
        cmd.emit   = (state_reg == S_EMIT) && sts.out_free;
        cmd.side   = side_reg;
        cmd.op     = op_reg;
    end

endmodule

`default_nettype wire

[sv/nmda_dpath.sv]
// nmda_dpath: registers, shared multiplier, exponent table, divider, output stage
// depends on nmda_pkg; steered by nmda_ctrl through cmd_t
`default_nettype none

module nmda_dpath import nmda_pkg::*; #(
    parameter int EXP_TABLE_DEPTH = NMDA_EXP_DEPTH
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  cmd_t                    cmd,
    output sts_t                    sts,
    input  wire logic               s_opcode,
    input  wire logic signed [15:0] s_voltage_now,
    input  wire logic signed [15:0] s_voltage_next,
    input  wire logic        [15:0] s_synaptic_weight,
    input  wire logic               cfg_write,
    input  wire logic         [2:0] cfg_index,
    input  wire logic        [31:0] cfg_data,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic signed      [47:0] m_current_now,
    output logic signed      [47:0] m_current_next,
    output logic                    m_still_active
);

    localparam int IDXW = (EXP_TABLE_DEPTH > 1) ? $clog2(EXP_TABLE_DEPTH) : 1;
    localparam int FDW  = 17 + IDXW;

    // configuration registers
    logic        [31:0] peak_reg;
    logic signed [15:0] rev_reg;
    logic        [15:0] rise_reg, fall_reg, norm_reg, mg_reg;
    logic        [19:0] shut_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_reg <= RST_PEAK;
            rev_reg  <= '0;
            rise_reg <= '0;
            fall_reg <= '0;
            norm_reg <= RST_NORM;
            mg_reg   <= RST_MG;
            shut_reg <= RST_SHUTDOWN;
        end else if (cfg_write) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_PEAK:     peak_reg <= cfg_data;
                CFG_REVERSAL: rev_reg  <= cfg_data[15:0];
                CFG_RISE:     rise_reg <= cfg_data[15:0];
                CFG_FALL:     fall_reg <= cfg_data[15:0];
                CFG_NORM:     norm_reg <= cfg_data[15:0];
                CFG_MG:       mg_reg   <= cfg_data[15:0];
                CFG_SHUTDOWN: shut_reg <= cfg_data[19:0];
                default: ;
            endcase
        end
    end

    // latched request fields
    logic signed [15:0] vn_reg, vx_reg;
    logic        [15:0] wt_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            vn_reg <= s_voltage_now;
            vx_reg <= s_voltage_next;
            wt_reg <= s_synaptic_weight;
        end
    end

    // working registers
    logic signed [61:0] prod_reg;
    logic signed [21:0] z_reg;
    logic        [16:0] tab_reg;
    logic signed [43:0] acc_reg;
    logic signed [43:0] res_now_reg, res_next_reg;
    logic        [31:0] rn_reg, rx_reg, fn_reg, fx_reg;
    logic        [19:0] ticks_reg;
    logic               active_reg;

    // side selection
    logic signed [15:0] v_sel;
    logic        [31:0] a_sel, b_sel;
    logic signed [32:0] diff;
    logic signed [16:0] drive;

    assign v_sel = cmd.side ? vx_reg : vn_reg;
    assign a_sel = cmd.side ? rx_reg : rn_reg;
    assign b_sel = cmd.side ? fx_reg : fn_reg;
    assign diff  = $signed({1'b0, b_sel}) - $signed({1'b0, a_sel});
    assign drive = 17'(rev_reg) - 17'(v_sel);

    // divider state
    logic        [54:0] rem_reg;
    logic        [53:0] den_reg;
    logic        [16:0] quo_reg;
    logic         [4:0] div_cnt_reg;

    // shared multiplier operand select
    logic signed [43:0] mul_a;
    logic signed [17:0] mul_b;

    always_comb begin
        unique case (cmd.op)
            OP_SPK_RISE: begin mul_a = 44'(peak_reg); mul_b = 18'(rise_reg); end
            OP_SPK_FALL: begin mul_a = 44'(peak_reg); mul_b = 18'(fall_reg); end
            OP_DEC_RN:   begin mul_a = 44'(rn_reg);   mul_b = 18'(rise_reg); end
            OP_DEC_RX:   begin mul_a = 44'(rx_reg);   mul_b = 18'(rise_reg); end
            OP_DEC_FN:   begin mul_a = 44'(fn_reg);   mul_b = 18'(fall_reg); end
            OP_DEC_FX:   begin mul_a = 44'(fx_reg);   mul_b = 18'(fall_reg); end
            OP_Z: begin
                mul_a = 44'(-NMDA_LOG2_SLOPE);
                mul_b = 18'(v_sel);
            end
            OP_T:        begin mul_a = 44'(tab_reg);  mul_b = 18'(mg_reg); end
            OP_P:        begin mul_a = 44'(diff);     mul_b = 18'(drive); end
            OP_W:        begin mul_a = acc_reg;       mul_b = 18'(wt_reg); end
            OP_N:        begin mul_a = acc_reg;       mul_b = 18'(norm_reg); end
            OP_B:        begin mul_a = acc_reg;       mul_b = 18'(quo_reg); end
            default:     begin mul_a = '0;            mul_b = '0; end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // exponent table from the fractional log2 part
    logic [16:0] tab_rom [EXP_TABLE_DEPTH];

    for (genvar i = 0; i < EXP_TABLE_DEPTH; i++) begin : g_tab
        localparam logic [15:0] FRAC = 16'((i * 65536) / EXP_TABLE_DEPTH);
        assign tab_rom[i] = pow2_frac(FRAC);
    end

    logic [FDW-1:0]  fd;
    logic [IDXW:0]   idx_w;
    logic [IDXW-1:0] idx;

    assign fd    = FDW'(z_reg[15:0]) * FDW'(EXP_TABLE_DEPTH);
    assign idx_w = fd[16 +: IDXW + 1];
    assign idx   = (idx_w >= (IDXW + 1)'(EXP_TABLE_DEPTH)) ?
                   IDXW'(EXP_TABLE_DEPTH - 1) : idx_w[IDXW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.lut) tab_reg <= tab_rom[idx];
    end

    // scale by the integer power of two and form the divisor
    logic signed [5:0] n_s;
    logic        [5:0] n_neg;
    logic        [4:0] n_pos;
    logic       [53:0] t_sh;

    assign n_s   = z_reg[21:16];
    assign n_neg = 6'(-n_s);
    assign n_pos = (n_s > 6'sd20) ? 5'd20 : n_s[4:0];

    always_comb begin
        if (n_s >= 0) t_sh = 54'(prod_reg[32:0]) << n_pos;
        else          t_sh = 54'(prod_reg[32:0]) >> n_neg;
    end

    // restoring divider, one quotient bit per cycle
    logic [54:0] rem_sh;
    logic        fits;

    assign rem_sh = {rem_reg[53:0], 1'b0};
    assign fits   = (rem_sh >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (cmd.wb && cmd.op == OP_T) begin
            div_cnt_reg <= 5'd17;
        end else if (cmd.div && div_cnt_reg != 5'd0) begin
            div_cnt_reg <= div_cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wb && cmd.op == OP_T) begin
            rem_reg <= 55'd1 << 27;
            den_reg <= (54'd1 << 28) + t_sh;
            quo_reg <= '0;
        end else if (cmd.div && div_cnt_reg != 5'd0) begin
            rem_reg <= fits ? rem_sh - {1'b0, den_reg} : rem_sh;
            quo_reg <= {quo_reg[15:0], fits};
        end
    end

    // saturating spike additions
    logic [31:0] spk_add;
    logic [32:0] sum_now_r, sum_next_r, sum_now_f, sum_next_f;

    assign spk_add    = prod_reg[47:16];
    assign sum_now_r  = {1'b0, rn_reg} + {1'b0, peak_reg};
    assign sum_next_r = {1'b0, rx_reg} + {1'b0, spk_add};
    assign sum_now_f  = {1'b0, fn_reg} + {1'b0, peak_reg};
    assign sum_next_f = {1'b0, fx_reg} + {1'b0, spk_add};

    // tick counter after increment
    logic [19:0] ticks_inc;
    assign ticks_inc = (ticks_reg == 20'hFFFFF) ? ticks_reg : ticks_reg + 20'd1;

    // synapse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rn_reg     <= '0;
            rx_reg     <= '0;
            fn_reg     <= '0;
            fx_reg     <= '0;
            ticks_reg  <= '0;
            active_reg <= 1'b0;
        end else begin
            if (cmd.accept) begin
                if (!s_opcode) begin
                    active_reg <= 1'b1;
                    ticks_reg  <= '0;
                end else if (active_reg) begin
                    ticks_reg  <= ticks_inc;
                    active_reg <= !(ticks_inc > shut_reg);
                end
            end
            if (cmd.wb) begin
                unique case (cmd.op)
                    OP_SPK_RISE: begin
                        rn_reg <= sum_now_r[32]  ? '1 : sum_now_r[31:0];
                        rx_reg <= sum_next_r[32] ? '1 : sum_next_r[31:0];
                    end
                    OP_SPK_FALL: begin
                        fn_reg <= sum_now_f[32]  ? '1 : sum_now_f[31:0];
                        fx_reg <= sum_next_f[32] ? '1 : sum_next_f[31:0];
                    end
                    OP_DEC_RN: rn_reg <= prod_reg[47:16];
                    OP_DEC_RX: rx_reg <= prod_reg[47:16];
                    OP_DEC_FN: fn_reg <= prod_reg[47:16];
                    OP_DEC_FX: fx_reg <= prod_reg[47:16];
                    default: ;
                endcase
            end
        end
    end

    // current chain writeback
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            res_now_reg  <= '0;
            res_next_reg <= '0;
        end else if (cmd.wb) begin
            unique case (cmd.op)
                OP_Z: z_reg   <= prod_reg[37:16];
                OP_P: acc_reg <= prod_reg[59:16];
                OP_W: acc_reg <= prod_reg[55:12];
                OP_N: acc_reg <= prod_reg[55:12];
                OP_B: begin
                    if (cmd.side) res_next_reg <= prod_reg[59:16];
                    else          res_now_reg  <= prod_reg[59:16];
                end
                default: ;
            endcase
        end
    end

    // output register
    logic out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_current_now  <= 48'(res_now_reg);
            m_current_next <= 48'(res_next_reg);
            m_still_active <= active_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

    // status
    always_comb begin
        sts.active   = active_reg;
        sts.div_done = (div_cnt_reg == 5'd0);
        sts.out_free = !out_valid_reg || m_tready;
    end

endmodule

`default_nettype wire

[sv/nmda_synapse_conductance.sv]
// nmda_synapse_conductance: top level of the nmda synapse block
// depends on nmda_pkg, nmda_ctrl and nmda_dpath
`default_nettype none

// One NMDA synapse with dual-exponential conductance and magnesium block.
// A request with tuser 0 is a spike: it gives no result. A request with
// tuser 1 is a tick: on an inactive synapse it returns zero currents; on an
// active one its work is paced by the single shared 44x18 multiplier
// (16 products) and the restoring divider (17 quotient bits) that forms
// the block factor, run once for each of the two currents. One request is
// worked on at a time; a finished result waits in the output register while
// the next request is taken. Configuration writes are taken at any time and
// should be made while the block is idle.
module nmda_synapse_conductance import nmda_pkg::*; #(
    parameter int EXP_TABLE_DEPTH = NMDA_EXP_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,  // voltage_now, voltage_next, synaptic_weight
    input  wire logic        s_tuser,  // opcode
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [95:0] m_tdata,  // current_now, current_next
    output logic             m_tuser,  // still_active
    // configuration channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic  [2:0] cfg_index,
    input  wire logic [31:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;
    logic signed [47:0] cur_now, cur_next;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {cur_next, cur_now};

    nmda_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_opcode (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    nmda_dpath #(
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_dpath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .s_opcode          (s_tuser),
        .s_voltage_now     (s_tdata[15:0]),
        .s_voltage_next    (s_tdata[31:16]),
        .s_synaptic_weight (s_tdata[47:32]),
        .cfg_write         (cfg_valid && cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_current_now     (cur_now),
        .m_current_next    (cur_next),
        .m_still_active    (m_tuser)
    );

endmodule

`default_nettype wire

[sv/nmda_checker.sv]
// nmda_checker: port-level assertions for the nmda synapse block
// depends on nmda_synapse_conductance; attached by bind
`default_nettype none

module nmda_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [95:0] m_tdata
);

    // result channel comes out of reset empty
    a_rst_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // one request at a time: busy the cycle after a request is taken
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // no result can appear the cycle right after a request is taken
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result without work");

endmodule

bind nmda_synapse_conductance nmda_checker u_nmda_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
